// ----- src/l2x_pkg.sv -----
// Shared types and fixed-point constants for the L*a*b* to XYZ converter.
`default_nettype none

package l2x_pkg;

    // Field widths
    localparam int L_W     = 15;
    localparam int AB_W    = 16;
    localparam int OUT_W   = 19;
    localparam int WHITE_W = 17;
    localparam int LS_W    = 16;
    localparam int F_W     = 22;
    localparam int FMAG_W  = 21;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // Pipeline depths
    localparam int PRE_STAGES = 4;
    localparam int CH_STAGES  = 6;

    typedef logic [CH_STAGES-1:0] t_ch_load;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

    // D50 white point
    localparam logic [WHITE_W-1:0] WHITE_X_RST = 17'd63189;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 17'd65536;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 17'd54060;

    // L+16 in 8 fraction bits
    localparam logic [LS_W-1:0] LS_OFFSET = 16'd4096;

    // Constant dividers: q = floor((num * 2^SH + HALF) / DIV), estimated
    // by a reciprocal multiply and fixed up by one remainder compare.
    localparam logic [25:0] RECIP_Y = 26'd37025580;  // 2^30 / 29
    localparam logic [22:0] RECIP_X = 23'd4739274;   // 2^34 / 3625
    localparam logic [23:0] RECIP_Z = 24'd11848185;  // 2^33 / 725
    localparam logic [4:0]  DIV_Y   = 5'd29;
    localparam logic [11:0] DIV_X   = 12'd3625;
    localparam logic [9:0]  DIV_Z   = 10'd725;
    localparam int HALF_Y = 14;
    localparam int HALF_X = 1812;
    localparam int HALF_Z = 362;

    // Q20 arithmetic
    localparam int FRAC        = 20;
    localparam int ROUND_HALF  = 524288;
    localparam int CUBE_THRESH = 9286;
    localparam int OFFSET_Q20  = 144631;
    localparam int INV_KAPPA   = 134657;
    localparam int KAPPA_W     = 18;
    localparam int OUT_POS_MAX = 262143;
    localparam int OUT_NEG_MAG = 262144;

endpackage

`default_nettype wire

// ----- src/l2x_channel.sv -----
// One tristimulus channel: cube or linear branch, white scaling, saturation.
`default_nettype none

module l2x_channel (
    input  logic                         i_clk,
    input  l2x_pkg::t_ch_load            i_load,
    input  logic [l2x_pkg::F_W-1:0]      i_f,      // Q20, two's complement
    input  logic [l2x_pkg::WHITE_W-1:0]  i_white,  // Q16, unsigned
    output logic [l2x_pkg::OUT_W-1:0]    o_res     // Q16, two's complement
);
    import l2x_pkg::*;

    localparam int SQ_P_W  = 2 * FMAG_W;
    localparam int SQ_W    = SQ_P_W - FRAC;
    localparam int CU_P_W  = SQ_W + FMAG_W;
    localparam int CU_W    = CU_P_W - FRAC;
    localparam int D_W     = F_W + 1;
    localparam int DMAG_W  = F_W;
    localparam int LIN_P_W = DMAG_W + KAPPA_W;
    localparam int LIN_W   = LIN_P_W - FRAC;
    localparam int WP_W    = CU_W + WHITE_W;
    localparam int WQ_W    = WP_W - FRAC;

    // stage 1
    logic [FMAG_W-1:0]  n_mag;
    logic [D_W-1:0]     n_d;
    logic               n_dneg;
    logic [DMAG_W-1:0]  n_dmag;
    logic [SQ_P_W-1:0]  n_sq_p;
    logic [LIN_P_W-1:0] n_lin_p;
    logic [SQ_P_W-1:0]  r_c1_sq_p;
    logic [LIN_P_W-1:0] r_c1_lin_p;
    logic [FMAG_W-1:0]  r_c1_mag;
    logic               r_c1_neg;
    logic               r_c1_dneg;
    // stage 2
    logic [SQ_W-1:0]    n_sq;
    logic [LIN_W-1:0]   n_vlin;
    logic [SQ_W-1:0]    r_c2_sq;
    logic [LIN_W-1:0]   r_c2_vlin;
    logic [FMAG_W-1:0]  r_c2_mag;
    logic               r_c2_neg;
    logic               r_c2_dneg;
    // stage 3
    logic [CU_P_W-1:0]  n_cu_p;
    logic [CU_P_W-1:0]  r_c3_cu_p;
    logic [LIN_W-1:0]   r_c3_vlin;
    logic               r_c3_neg;
    logic               r_c3_dneg;
    // stage 4
    logic [CU_W-1:0]    n_cmag;
    logic               n_take_cube;
    logic [CU_W-1:0]    n_vmag;
    logic               n_vneg;
    logic [CU_W-1:0]    r_c4_vmag;
    logic               r_c4_vneg;
    // stage 5
    logic [WP_W-1:0]    n_wp;
    logic [WP_W-1:0]    r_c5_wp;
    logic               r_c5_vneg;
    // stage 6
    logic [WQ_W-1:0]    n_wq;
    logic [OUT_W-1:0]   n_res;
    logic [OUT_W-1:0]   r_res;

    always_comb begin
        n_mag   = i_f[F_W-1] ? FMAG_W'(F_W'(0) - i_f) : FMAG_W'(i_f);
        n_d     = {i_f[F_W-1], i_f} - D_W'(OFFSET_Q20);
        n_dneg  = n_d[D_W-1];
        n_dmag  = n_dneg ? DMAG_W'(D_W'(0) - n_d) : DMAG_W'(n_d);
        n_sq_p  = {{FMAG_W{1'b0}}, n_mag} * {{FMAG_W{1'b0}}, n_mag};
        n_lin_p = {{KAPPA_W{1'b0}}, n_dmag} * LIN_P_W'(INV_KAPPA);
    end

    always_comb begin
        n_sq   = SQ_W'((r_c1_sq_p + SQ_P_W'(ROUND_HALF)) >> FRAC);
        n_vlin = LIN_W'((r_c1_lin_p + LIN_P_W'(ROUND_HALF)) >> FRAC);
    end

    assign n_cu_p = {{FMAG_W{1'b0}}, r_c2_sq} * {{SQ_W{1'b0}}, r_c2_mag};

    // Negative f never clears the threshold: take the linear branch.
    always_comb begin
        n_cmag      = CU_W'((r_c3_cu_p + CU_P_W'(ROUND_HALF)) >> FRAC);
        n_take_cube = !r_c3_neg && (n_cmag > CU_W'(CUBE_THRESH));
        n_vmag      = n_take_cube ? n_cmag : CU_W'(r_c3_vlin);
        n_vneg      = !n_take_cube && r_c3_dneg;
    end

    assign n_wp = {{WHITE_W{1'b0}}, r_c4_vmag} * {{CU_W{1'b0}}, i_white};

    always_comb begin
        n_wq = WQ_W'((r_c5_wp + WP_W'(ROUND_HALF)) >> FRAC);
        if (!r_c5_vneg) begin
            n_res = (n_wq > WQ_W'(OUT_POS_MAX)) ? OUT_W'(OUT_POS_MAX) : OUT_W'(n_wq);
        end else begin
            n_res = (n_wq > WQ_W'(OUT_NEG_MAG)) ? OUT_W'(OUT_NEG_MAG)
                                                 : OUT_W'(WQ_W'(0) - n_wq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_c1_sq_p  <= n_sq_p;
            r_c1_lin_p <= n_lin_p;
            r_c1_mag   <= n_mag;
            r_c1_neg   <= i_f[F_W-1];
            r_c1_dneg  <= n_dneg;
        end
        if (i_load[1]) begin
            r_c2_sq   <= n_sq;
            r_c2_vlin <= n_vlin;
            r_c2_mag  <= r_c1_mag;
            r_c2_neg  <= r_c1_neg;
            r_c2_dneg <= r_c1_dneg;
        end
        if (i_load[2]) begin
            r_c3_cu_p <= n_cu_p;
            r_c3_vlin <= r_c2_vlin;
            r_c3_neg  <= r_c2_neg;
            r_c3_dneg <= r_c2_dneg;
        end
        if (i_load[3]) begin
            r_c4_vmag <= n_vmag;
            r_c4_vneg <= n_vneg;
        end
        if (i_load[4]) begin
            r_c5_wp   <= n_wp;
            r_c5_vneg <= r_c4_vneg;
        end
        if (i_load[5]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- src/lab_to_xyz.sv -----
// Top level of the CIE L*a*b* to XYZ pixel converter.
//
// Pixels enter on the s_axis channel, one L*a*b* triple per transfer, and
// leave on m_axis as one XYZ triple per transfer, in the same order.
// The white point sits in three registers written over the cfg channel
// (index 0 X, 1 Y, 2 Z; other indexes are ignored); o_cfg_ready is always
// high. Write them only while no pixel is in flight.
// The pipe runs from input transfer to output transfer in two parts:
// four stages form fx, fy and fz through reciprocal-multiply dividers, six
// stages per channel cube, select, scale by the white point and saturate.
// Throughput is one pixel per cycle unless m_axis stalls; each stage
// holds its own valid bit. When the receiver stalls, the output holds and
// bubbles inside the pipe close up, so new pixels are taken until every
// stage is full, then s_axis_tready drops. Nothing is lost or repeated.
// Reset empties the pipeline and loads the D50 white point.
`default_nettype none

module lab_to_xyz (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // lightness[14:0], green_red[30:15], blue_yellow[46:31], zero[47]
    input  logic [l2x_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x[18:0], out_y[37:19], out_z[56:38], zero[63:57]
    output logic [l2x_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [l2x_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [l2x_pkg::WHITE_W-1:0]       i_cfg_data
);
    import l2x_pkg::*;

    localparam int NS = PRE_STAGES + CH_STAGES;

    logic [WHITE_W-1:0] r_white_x;
    logic [WHITE_W-1:0] r_white_y;
    logic [WHITE_W-1:0] r_white_z;

    logic [NS-1:0] r_vld;
    logic [NS:0]   stage_load;
    logic          in_xfer;
    logic          out_xfer;

    // stage 1: scaled numerators in sign-magnitude
    logic [L_W-1:0]  in_l;
    logic [AB_W-1:0] in_a;
    logic [AB_W-1:0] in_b;
    logic [LS_W-1:0] n_ls;
    logic [24:0]     n_nx;
    logic [24:0]     n_nz;
    logic [LS_W-1:0] r1_ls;
    logic [22:0]     r1_nx_mag;
    logic            r1_nx_neg;
    logic [21:0]     r1_nz_mag;
    logic            r1_nz_neg;
    // stage 2: quotient estimates
    logic [41:0]       n_py;
    logic [45:0]       n_px;
    logic [45:0]       n_pz;
    logic [FMAG_W-1:0] r2_q0y;
    logic [FMAG_W-1:0] r2_q0x;
    logic [FMAG_W-1:0] r2_q0z;
    logic [LS_W-1:0]   r2_ls;
    logic [22:0]       r2_nx_mag;
    logic              r2_nx_neg;
    logic [21:0]       r2_nz_mag;
    logic              r2_nz_neg;
    // stage 3: remainders
    logic [25:0]       n_ny;
    logic [25:0]       n_my;
    logic [32:0]       n_nxs;
    logic [32:0]       n_mx;
    logic [30:0]       n_nzs;
    logic [30:0]       n_mz;
    logic [25:0]       n_ry_full;
    logic [32:0]       n_rx_full;
    logic [30:0]       n_rz_full;
    logic [FMAG_W-1:0] r3_q0y;
    logic [FMAG_W-1:0] r3_q0x;
    logic [FMAG_W-1:0] r3_q0z;
    logic [5:0]        r3_ry;
    logic [12:0]       r3_rx;
    logic [10:0]       r3_rz;
    logic              r3_nx_neg;
    logic              r3_nz_neg;
    // stage 4: rounded f values
    logic [FMAG_W-1:0] n_qy;
    logic [FMAG_W-1:0] n_qx;
    logic [FMAG_W-1:0] n_qz;
    logic [F_W-1:0]    r4_fy;
    logic [F_W-1:0]    r4_fx;
    logic [F_W-1:0]    r4_fz;

    logic [OUT_W-1:0] res_x;
    logic [OUT_W-1:0] res_y;
    logic [OUT_W-1:0] res_z;
    t_ch_load         ch_load;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_x <= WHITE_X_RST;
            r_white_y <= WHITE_Y_RST;
            r_white_z <= WHITE_Z_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WHITE_X: r_white_x <= i_cfg_data;
                REG_WHITE_Y: r_white_y <= i_cfg_data;
                REG_WHITE_Z: r_white_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_load[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_load[k] = !r_vld[k] || stage_load[k+1];
        end
    end

    assign s_axis_tready = stage_load[0];
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_load[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1
    always_comb begin
        in_l = s_axis_tdata[L_W-1:0];
        in_a = s_axis_tdata[L_W+AB_W-1:L_W];
        in_b = s_axis_tdata[L_W+2*AB_W-1:L_W+AB_W];
        n_ls = LS_W'({1'b0, in_l}) + LS_OFFSET;
        n_nx = {9'd0, n_ls} * 25'd125 + {{9{in_a[AB_W-1]}}, in_a} * 25'd29;
        n_nz = {9'd0, n_ls} * 25'd50 - {{9{in_b[AB_W-1]}}, in_b} * 25'd29;
    end

    // Stage 2
    always_comb begin
        n_py = {26'd0, r1_ls} * {16'd0, RECIP_Y};
        n_px = {23'd0, r1_nx_mag} * {23'd0, RECIP_X};
        n_pz = {24'd0, r1_nz_mag} * {22'd0, RECIP_Z};
    end

    // Stage 3: the estimate is exact or one short; remainder tells which.
    always_comb begin
        n_ny      = {r2_ls, 10'd0} + 26'(HALF_Y);
        n_my      = {5'd0, r2_q0y} * {21'd0, DIV_Y};
        n_nxs     = {r2_nx_mag, 10'd0} + 33'(HALF_X);
        n_mx      = {12'd0, r2_q0x} * {21'd0, DIV_X};
        n_nzs     = {r2_nz_mag, 9'd0} + 31'(HALF_Z);
        n_mz      = {10'd0, r2_q0z} * {21'd0, DIV_Z};
        n_ry_full = n_ny - n_my;
        n_rx_full = n_nxs - n_mx;
        n_rz_full = n_nzs - n_mz;
    end

    // Stage 4
    always_comb begin
        n_qy = r3_q0y + FMAG_W'(r3_ry >= {1'b0, DIV_Y});
        n_qx = r3_q0x + FMAG_W'(r3_rx >= {1'b0, DIV_X});
        n_qz = r3_q0z + FMAG_W'(r3_rz >= {1'b0, DIV_Z});
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[0]) begin
            r1_ls     <= n_ls;
            r1_nx_neg <= n_nx[24];
            r1_nx_mag <= 23'(n_nx[24] ? (25'd0 - n_nx) : n_nx);
            r1_nz_neg <= n_nz[24];
            r1_nz_mag <= 22'(n_nz[24] ? (25'd0 - n_nz) : n_nz);
        end
        if (stage_load[1]) begin
            r2_q0y    <= n_py[40:20];
            r2_q0x    <= n_px[44:24];
            r2_q0z    <= n_pz[44:24];
            r2_ls     <= r1_ls;
            r2_nx_mag <= r1_nx_mag;
            r2_nx_neg <= r1_nx_neg;
            r2_nz_mag <= r1_nz_mag;
            r2_nz_neg <= r1_nz_neg;
        end
        if (stage_load[2]) begin
            r3_q0y    <= r2_q0y;
            r3_q0x    <= r2_q0x;
            r3_q0z    <= r2_q0z;
            r3_ry     <= n_ry_full[5:0];
            r3_rx     <= n_rx_full[12:0];
            r3_rz     <= n_rz_full[10:0];
            r3_nx_neg <= r2_nx_neg;
            r3_nz_neg <= r2_nz_neg;
        end
        if (stage_load[3]) begin
            r4_fy <= {1'b0, n_qy};
            r4_fx <= r3_nx_neg ? (F_W'(0) - {1'b0, n_qx}) : {1'b0, n_qx};
            r4_fz <= r3_nz_neg ? (F_W'(0) - {1'b0, n_qz}) : {1'b0, n_qz};
        end
    end

    assign ch_load = stage_load[NS-1:PRE_STAGES];

    l2x_channel u_ch_x (
        .i_clk   (i_clk),
        .i_load  (ch_load),
        .i_f     (r4_fx),
        .i_white (r_white_x),
        .o_res   (res_x)
    );

    l2x_channel u_ch_y (
        .i_clk   (i_clk),
        .i_load  (ch_load),
        .i_f     (r4_fy),
        .i_white (r_white_y),
        .o_res   (res_y)
    );

    l2x_channel u_ch_z (
        .i_clk   (i_clk),
        .i_load  (ch_load),
        .i_f     (r4_fz),
        .i_white (r_white_z),
        .o_res   (res_z)
    );

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {(M_TDATA_W - 3 * OUT_W)'(0), res_z, res_y, res_x};

    // Items in flight change only by transfers at either end.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) ==
                  $past($countones(r_vld)) + int'($past(in_xfer)) - int'($past(out_xfer))))
        else $error("pipeline occupancy does not match transfers");

    // A full, stalled pipe must refuse input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full and stalled");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for lab_to_xyz: directed and random pixels checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_top;

    import l2x_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DUT_LATENCY  = 10;
    localparam int IDLE_PCT     = 35;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 260;
    localparam int STEADY_PHASE = 2;
    localparam int RUN_LIMIT_NS = 2_000_000;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Q20 arithmetic of the conversion
    localparam int     Q20_BITS   = 20;
    localparam longint Q20_ONE    = 64'sd1048576;
    localparam longint Q20_HALF   = 64'sd524288;
    localparam longint LS_BIAS    = 64'sd4096;     // L+16 with 8 fraction bits
    localparam longint DEN_Y      = 64'sd29696;    // 116 * 256
    localparam longint DEN_X      = 64'sd3712000;  // 116 * 500 * 256 / 4
    localparam longint DEN_Z      = 64'sd1484800;  // 116 * 200 * 256 / 4
    localparam longint CUBE_LIMIT = 64'sd9286;     // 0.008856
    localparam longint BEND_Q20   = 64'sd144631;   // 16/116
    localparam longint SLOPE_Q20  = 64'sd134657;   // 1/7.787
    localparam longint SAT_HI     = 64'sd262143;
    localparam longint SAT_LO     = -64'sd262144;

    typedef struct packed {
        logic [L_W-1:0]  lightness;
        logic [AB_W-1:0] green_red;
        logic [AB_W-1:0] blue_yellow;
    } t_pixel;

    typedef struct packed {
        logic [OUT_W-1:0] out_x;
        logic [OUT_W-1:0] out_y;
        logic [OUT_W-1:0] out_z;
    } t_xyz;

    typedef enum logic {ROW_PIX, ROW_WR} t_row_kind;

    localparam logic [2:0] PIN_NONE = 3'b000;
    localparam logic [2:0] PIN_X    = 3'b001;
    localparam logic [2:0] PIN_Y    = 3'b010;
    localparam logic [2:0] PIN_Z    = 3'b100;
    localparam logic [2:0] PIN_XZ   = PIN_X | PIN_Z;
    localparam logic [2:0] PIN_ALL  = PIN_X | PIN_Y | PIN_Z;

    localparam t_xyz XYZ_ZERO = '0;
    localparam t_xyz XYZ_SAT  = '{19'd262143, 19'd262143, 19'd262143};

    // Pinned fields of a row take the typed value instead of the predicted one.
    typedef struct packed {
        t_row_kind              kind;
        t_pixel                 px;
        logic [2:0]             pin;
        t_xyz                   xyz;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [WHITE_W-1:0]     wdata;
    } t_row;

    t_row plan [0:29] = '{
        // black point lands exactly on the knee offset: zero on every channel
        '{ROW_PIX, '{15'd0,     16'h0000, 16'h0000}, PIN_ALL,  XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd25600, 16'h0000, 16'h0000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd32767, 16'h7fff, 16'h8000}, PIN_Z,    XYZ_SAT,  REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd0,     16'h8000, 16'h7fff}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd0,     16'h7fff, 16'h8000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        // L* = 8 puts fy on the cube/linear knee
        '{ROW_PIX, '{15'd2047,  16'h0000, 16'h0000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd2048,  16'h0000, 16'h0000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd2049,  16'h0000, 16'h0000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd12800, 16'h8000, 16'h8000}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd25600, 16'h7fff, 16'h7fff}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        // lightness past 100 goes through unclamped
        '{ROW_PIX, '{15'd25601, 16'hffff, 16'h0001}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_X, 17'd0},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Y, 17'd0},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Z, 17'd0},
        '{ROW_PIX, '{15'd32767, 16'h7fff, 16'h8000}, PIN_ALL,  XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd0,     16'h8000, 16'h7fff}, PIN_ALL,  XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_X, 17'd131071},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Y, 17'd131071},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Z, 17'd131071},
        '{ROW_PIX, '{15'd32767, 16'h7fff, 16'h8000}, PIN_XZ,   XYZ_SAT,  REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd0,     16'h8000, 16'h7fff}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'd0,     16'h0000, 16'h0000}, PIN_ALL,  XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'h5555,  16'haaaa, 16'h5555}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        '{ROW_PIX, '{15'h2aaa,  16'h5555, 16'haaaa}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0},
        // unused index must leave X and Z at full scale
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_SPARE,   17'd0},
        '{ROW_PIX, '{15'd32767, 16'h7fff, 16'h8000}, PIN_XZ,   XYZ_SAT,  REG_WHITE_X, '0},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_X, WHITE_X_RST},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Y, WHITE_Y_RST},
        '{ROW_WR,  '0, PIN_NONE, XYZ_ZERO, REG_WHITE_Z, WHITE_Z_RST},
        '{ROW_PIX, '{15'd9000,  16'h0100, 16'hff00}, PIN_NONE, XYZ_ZERO, REG_WHITE_X, '0}
    };

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [REG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [WHITE_W-1:0]       i_cfg_data    = '0;

    logic [WHITE_W-1:0] white_x = WHITE_X_RST;
    logic [WHITE_W-1:0] white_y = WHITE_Y_RST;
    logic [WHITE_W-1:0] white_z = WHITE_Z_RST;

    t_xyz pending_xyz[$];
    logic steady = 1'b0;
    int   mismatches;
    int   pixels_sent;
    int   results_seen;
    int   writes_done;

    lab_to_xyz u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic longint div_near(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint round_q20(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + Q20_HALF) >>> Q20_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic [OUT_W-1:0] scale_channel(longint f, logic [WHITE_W-1:0] white);
        longint mag;
        longint cube;
        longint v;
        longint r;
        mag  = (f < 0) ? -f : f;
        cube = round_q20(round_q20(mag * mag) * mag);
        if (f < 0)
            cube = -cube;
        // above the knee the cube stands, below it the straight segment
        v = (cube > CUBE_LIMIT) ? cube : round_q20((f - BEND_Q20) * SLOPE_Q20);
        r = round_q20(v * longint'(white));
        if (r > SAT_HI)
            r = SAT_HI;
        if (r < SAT_LO)
            r = SAT_LO;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_xyz convert_pixel(t_pixel px);
        longint ls;
        longint a;
        longint b;
        t_xyz   c;
        ls = longint'(px.lightness) + LS_BIAS;
        a  = longint'($signed(px.green_red));
        b  = longint'($signed(px.blue_yellow));
        c.out_x = scale_channel(div_near((ls * 125 + a * 29) * Q20_ONE, DEN_X), white_x);
        c.out_y = scale_channel(div_near(ls * Q20_ONE, DEN_Y), white_y);
        c.out_z = scale_channel(div_near((ls * 50 - b * 29) * Q20_ONE, DEN_Z), white_z);
        return c;
    endfunction

    function automatic logic [WHITE_W-1:0] pick_white();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return WHITE_W'($urandom);
        endcase
    endfunction

    function automatic int field_bad(string name, logic [OUT_W-1:0] want,
                                     logic [OUT_W-1:0] got);
        if (want == got)
            return 0;
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        return 1;
    endfunction

    task automatic send_pixel(t_pixel px, t_xyz want);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
            gap++;
        // close any register transfer still standing
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, px.blue_yellow, px.green_red, px.lightness};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_xyz.push_back(want);
        pixels_sent++;
    endtask

    task automatic write_white(logic [REG_IDX_W-1:0] idx, logic [WHITE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        // hold the write until every pixel in flight has come out
        while (pending_xyz.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WHITE_X: white_x = value;
            REG_WHITE_Y: white_y = value;
            REG_WHITE_Z: white_z = value;
            default: ;
        endcase
        writes_done++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    t_xyz due;
    t_xyz seen;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.out_x = m_axis_tdata[OUT_W-1:0];
            seen.out_y = m_axis_tdata[2*OUT_W-1:OUT_W];
            seen.out_z = m_axis_tdata[3*OUT_W-1:2*OUT_W];
            if (pending_xyz.size() == 0) begin
                $error("result transfer with nothing outstanding: x %0d y %0d z %0d",
                       $signed(seen.out_x), $signed(seen.out_y), $signed(seen.out_z));
                mismatches++;
            end else begin
                due = pending_xyz.pop_front();
                mismatches += field_bad("out_x", due.out_x, seen.out_x)
                            + field_bad("out_y", due.out_y, seen.out_y)
                            + field_bad("out_z", due.out_z, seen.out_z);
                results_seen++;
            end
        end
    end

    t_pixel px;
    t_xyz   want;

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WR) begin
                write_white(plan[k].reg_idx, plan[k].wdata);
            end else begin
                want = convert_pixel(plan[k].px);
                if (plan[k].pin & PIN_X)
                    want.out_x = plan[k].xyz.out_x;
                if (plan[k].pin & PIN_Y)
                    want.out_y = plan[k].xyz.out_y;
                if (plan[k].pin & PIN_Z)
                    want.out_z = plan[k].xyz.out_z;
                send_pixel(plan[k].px, want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            steady <= (p == STEADY_PHASE);
            write_white(REG_WHITE_X, pick_white());
            write_white(REG_WHITE_Y, pick_white());
            write_white(REG_WHITE_Z, pick_white());
            write_white(REG_SPARE, WHITE_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0, 1: px.lightness = L_W'($urandom_range(2052, 2044));
                    2: px.lightness = L_W'($urandom);
                    default: px.lightness = L_W'($urandom_range(25600));
                endcase
                // small chroma keeps fx and fz near the knee as well
                if ($urandom_range(3) == 0) begin
                    px.green_red   = AB_W'($urandom_range(1023)) - AB_W'(512);
                    px.blue_yellow = AB_W'($urandom_range(1023)) - AB_W'(512);
                end else begin
                    px.green_red   = AB_W'($urandom);
                    px.blue_yellow = AB_W'($urandom);
                end
                send_pixel(px, convert_pixel(px));
            end
        end

        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b0;
        while (pending_xyz.size() != 0) @(posedge i_clk);
        // catch any stray result after the pipe should be empty
        repeat (4 * DUT_LATENCY) @(posedge i_clk);

        $display("%0d pixels sent over %0d white-point writes, %0d XYZ results compared",
                 pixels_sent, writes_done, results_seen);
        $display("%0d mismatching results or fields", mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("run limit reached with %0d results outstanding", pending_xyz.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
